FILE: rtl/core/fds_pkg.sv
// Shared constants and saturation helpers for the focus distance smoother.
// Used by the multiply unit, the reciprocal unit and the top level.
package fds_pkg;

    localparam int CFG_W     = 31;
    localparam int NUM_CFG   = 8;
    localparam int MAG_A_W   = 63;
    localparam int MAG_B_W   = 48;
    localparam int DEN_W     = 62;
    localparam int QUOT_W    = 33;

    localparam logic signed [63:0] ONE_Q16   = 64'sd65536;
    localparam logic signed [63:0] SPEED_MAX = 64'sd655360000;
    localparam logic signed [63:0] WIDE_LIM  = 64'sd140737488355327;
    localparam logic [110:0]       MUL_LIM   = 111'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [33:0]        EXP_C2    = 34'd31457;
    localparam logic [33:0]        EXP_C3    = 34'd15401;

    // Register indexes
    localparam logic [2:0] REG_MIN_DIST  = 3'd0;
    localparam logic [2:0] REG_MAX_DIST  = 3'd1;
    localparam logic [2:0] REG_SW_THR    = 3'd2;
    localparam logic [2:0] REG_HOLD_TIME = 3'd3;
    localparam logic [2:0] REG_DEADZONE  = 3'd4;
    localparam logic [2:0] REG_SPD_CLOSE = 3'd5;
    localparam logic [2:0] REG_SPD_FAR   = 3'd6;
    localparam logic [2:0] REG_MAX_RATE  = 3'd7;

    // Saturate to the wide intermediate range
    function automatic logic signed [63:0] satw(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > WIDE_LIM)
            r = WIDE_LIM;
        else if (v < -WIDE_LIM)
            r = -WIDE_LIM;
        return r;
    endfunction

    // Saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        r = v[31:0];
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        return r;
    endfunction

endpackage

FILE: rtl/core/fds_mul.sv
// Shared signed multiply unit: magnitude times 16-bit digits in turn from the top,
// then a truncating shift by 16 or 32 with saturation. Depends on fds_pkg.
module fds_mul
    import fds_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [33:0] b,
    input  logic               sh32,
    output logic               done,
    output logic signed [63:0] result
);

    logic [MAG_A_W-1:0] amag_reg, amag_next;
    logic [MAG_B_W-1:0] bmag_reg, bmag_next;
    logic [110:0]       acc_reg, acc_next;
    logic               neg_reg, neg_next;
    logic               sh32_reg, sh32_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [63:0]        a_abs;
    logic [33:0]        b_abs;
    logic [78:0]        part;
    logic [110:0]       shifted;
    logic [62:0]        mag;

    assign a_abs = a[63] ? 64'(-a) : 64'(a);
    assign b_abs = b[33] ? 34'(-b) : 34'(b);
    assign part  = 79'(amag_reg) * 79'(bmag_reg[47:32]);

    // Load operands, then accumulate one digit a cycle from the top
    always_comb
    begin
        amag_next = amag_reg;
        bmag_next = bmag_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        sh32_next = sh32_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            amag_next = a_abs[MAG_A_W-1:0];
            bmag_next = {14'd0, b_abs};
            acc_next  = '0;
            neg_next  = a[63] ^ b[33];
            sh32_next = sh32;
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        else if (busy_reg)
        begin
            acc_next  = {acc_reg[94:0], 16'd0} + 111'(part);
            bmag_next = {bmag_reg[31:0], 16'd0};
            cnt_next  = cnt_reg + 2'd1;
            if (cnt_reg == 2'd2)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amag_reg <= amag_next;
        bmag_reg <= bmag_next;
        acc_reg  <= acc_next;
        neg_reg  <= neg_next;
        sh32_reg <= sh32_next;
    end

    // Shift, saturate, apply sign
    assign shifted = sh32_reg ? (acc_reg >> 32) : (acc_reg >> 16);
    assign mag     = (shifted > MUL_LIM) ? MUL_LIM[62:0] : shifted[62:0];
    assign result  = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign done    = done_reg;

endmodule

FILE: rtl/core/fds_div.sv
// Restoring reciprocal unit: floor(2^48 / den), one quotient bit a cycle.
// Depends on fds_pkg.
module fds_div
    import fds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [48:0]      q_reg, q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg[DEN_W-1:0], (cnt_reg == 6'd48)};
    assign fits  = trial >= {1'b0, den_reg};

    // Shift in one dividend bit, subtract when it fits
    always_comb
    begin
        den_next  = den_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 6'd48;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial - {1'b0, den_reg} : trial;
            q_next   = {q_reg[47:0], fits};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg <= den_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign quot = q_reg[QUOT_W-1:0];

endmodule

FILE: rtl/core/focus_distance_smoother.sv
// Focus distance smoother: clamp, hold hysteresis, deadzone, critically damped
// spring and slew limit on Q16.16 distances. Depends on fds_pkg, fds_mul, fds_div.
// Each accepted input steps through the clamp, hold and deadzone states, five products
// on the shared 63x16 multiply unit, the bit-serial reciprocal, five more products,
// the overshoot snap, the slew-step product, then the slew and output states. One
// input at a time; s_tready is high only when idle. Reset (rst_n, async, active low).
module focus_distance_smoother
    import fds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [47:0]       s_tdata,    // measured_distance[31:0], time_step[47:32]
    input  logic              s_tuser,    // hold_mode
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,    // focus_distance[31:0]
    output logic              m_tuser,    // holding
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_CLAMP = 12'b000000000010,
        S_HOLD  = 12'b000000000100,
        S_DZ    = 12'b000000001000,
        S_MGO   = 12'b000000010000,
        S_MWAIT = 12'b000000100000,
        S_DGO   = 12'b000001000000,
        S_DWAIT = 12'b000010000000,
        S_SNAP  = 12'b000100000000,
        S_SLEW  = 12'b001000000000,
        S_FIN   = 12'b010000000000,
        S_SPARE = 12'b100000000000
    } state_t;

    typedef enum logic [3:0] {
        OP_X, OP_X2, OP_X3, OP_P2, OP_P3, OP_M, OP_TEMP, OP_Q, OP_NV, OP_R, OP_STEP
    } op_t;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic [CFG_W-1:0] cfg_reg [NUM_CFG];

    logic signed [31:0] smooth_reg, velo_reg, stable_reg;
    logic [31:0]        timer_reg;
    logic signed [31:0] d_reg;
    logic [15:0]        dt_reg;
    logic               hmode_reg, holding_reg;
    logic [30:0]        om_reg;
    logic signed [63:0] x_reg, x2_reg, x3_reg, p2_reg, p3_reg;
    logic [QUOT_W-1:0]  ex_reg;
    logic signed [63:0] t1_reg, temp_reg, av_reg, nv_reg, res_reg, step_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_hold_reg;

    logic               mul_start, mul_done, mul_sh32;
    logic signed [63:0] mul_a, mul_result;
    logic signed [33:0] mul_b;
    logic               div_start, div_done;
    logic [QUOT_W-1:0]  div_quot;
    logic signed [63:0] den;
    logic signed [63:0] change, ct_sum;

    logic [CFG_W-1:0]   lo, hi;
    logic signed [32:0] din, dclamp, jump_s, delta;
    logic [32:0]        jump, tsum, dmag;
    logic [CFG_W-1:0]   speed_raw;
    logic signed [63:0] speed, snap_res, lo_b, hi_b;

    fds_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .sh32   (mul_sh32),
        .done   (mul_done),
        .result (mul_result)
    );

    fds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .den   (den[DEN_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_hold_reg;
    assign mul_start = (state_reg == S_MGO);
    assign div_start = (state_reg == S_DGO);

    assign change = 64'(smooth_reg) - 64'(d_reg);
    assign ct_sum = satw(change + temp_reg);
    assign den    = ONE_Q16 + x_reg + p2_reg + p3_reg;

    // Clamp limits, swapped when reversed
    assign lo     = (cfg_reg[REG_MIN_DIST] > cfg_reg[REG_MAX_DIST]) ?
                    cfg_reg[REG_MAX_DIST] : cfg_reg[REG_MIN_DIST];
    assign hi     = (cfg_reg[REG_MIN_DIST] > cfg_reg[REG_MAX_DIST]) ?
                    cfg_reg[REG_MIN_DIST] : cfg_reg[REG_MAX_DIST];
    assign din    = 33'(signed'(s_tdata[31:0]));
    assign dclamp = (din < $signed({2'b00, lo})) ? $signed({2'b00, lo}) :
                    (din > $signed({2'b00, hi})) ? $signed({2'b00, hi}) : din;

    // Hold timing terms
    assign jump_s = 33'(d_reg) - 33'(stable_reg);
    assign jump   = jump_s[32] ? 33'(-jump_s) : 33'(jump_s);
    assign tsum   = 33'(timer_reg) + 33'(dt_reg);

    // Deadzone and speed terms
    assign delta     = 33'(d_reg) - 33'(smooth_reg);
    assign dmag      = delta[32] ? 33'(-delta) : 33'(delta);
    assign speed_raw = delta[32] ? cfg_reg[REG_SPD_CLOSE] : cfg_reg[REG_SPD_FAR];
    assign speed     = (64'(speed_raw) < ONE_Q16) ? ONE_Q16 :
                       (64'(speed_raw) > SPEED_MAX) ? SPEED_MAX : 64'(speed_raw);

    // Overshoot snap and slew bounds
    assign snap_res = ((change < 0) == (res_reg > 64'(d_reg))) ? 64'(d_reg) : res_reg;
    assign lo_b     = 64'(smooth_reg) - step_reg;
    assign hi_b     = 64'(smooth_reg) + step_reg;

    // Select operands of the shared multiply
    always_comb
    begin
        mul_a    = 64'(om_reg);
        mul_b    = 34'(dt_reg);
        mul_sh32 = 1'b0;
        case (op_reg)
            OP_X:
            begin
                mul_a = 64'(om_reg);
                mul_b = 34'(dt_reg);
            end
            OP_X2:
            begin
                mul_a = x_reg;
                mul_b = x_reg[33:0];
            end
            OP_X3:
            begin
                mul_a = x2_reg;
                mul_b = x_reg[33:0];
            end
            OP_P2:
            begin
                mul_a = x2_reg;
                mul_b = EXP_C2;
            end
            OP_P3:
            begin
                mul_a = x3_reg;
                mul_b = EXP_C3;
            end
            OP_M:
            begin
                mul_a = change;
                mul_b = 34'(om_reg);
            end
            OP_TEMP:
            begin
                mul_a = t1_reg;
                mul_b = 34'(dt_reg);
            end
            OP_Q:
            begin
                mul_a = temp_reg;
                mul_b = 34'(om_reg);
            end
            OP_NV:
            begin
                mul_a    = av_reg;
                mul_b    = 34'(ex_reg);
                mul_sh32 = 1'b1;
            end
            OP_R:
            begin
                mul_a    = ct_sum;
                mul_b    = 34'(ex_reg);
                mul_sh32 = 1'b1;
            end
            OP_STEP:
            begin
                mul_a = 64'(cfg_reg[REG_MAX_RATE]);
                mul_b = 34'(dt_reg);
            end
            default:
            begin
                mul_a = 64'(om_reg);
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                    state_next = S_CLAMP;
            S_CLAMP:
                state_next = S_HOLD;
            S_HOLD:
                state_next = S_DZ;
            S_DZ:
            begin
                op_next    = OP_X;
                state_next = S_MGO;
            end
            S_MGO:
                state_next = S_MWAIT;
            S_MWAIT:
                if (mul_done)
                begin
                    case (op_reg)
                        OP_P3:
                            state_next = S_DGO;
                        OP_R:
                            state_next = S_SNAP;
                        OP_STEP:
                            state_next = S_SLEW;
                        default:
                        begin
                            op_next    = op_t'(op_reg + 4'd1);
                            state_next = S_MGO;
                        end
                    endcase
                end
            S_DGO:
                state_next = S_DWAIT;
            S_DWAIT:
                if (div_done)
                begin
                    op_next    = OP_M;
                    state_next = S_MGO;
                end
            S_SNAP:
            begin
                op_next    = OP_STEP;
                state_next = S_MGO;
            end
            S_SLEW:
                state_next = S_FIN;
            S_FIN:
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= S_IDLE;
            op_reg                   <= OP_X;
            cfg_reg[REG_MIN_DIST]    <= '0;
            cfg_reg[REG_MAX_DIST]    <= 31'h7FFF_FFFF;
            cfg_reg[REG_SW_THR]      <= '0;
            cfg_reg[REG_HOLD_TIME]   <= '0;
            cfg_reg[REG_DEADZONE]    <= '0;
            cfg_reg[REG_SPD_CLOSE]   <= 31'd65536;
            cfg_reg[REG_SPD_FAR]     <= 31'd65536;
            cfg_reg[REG_MAX_RATE]    <= '0;
            smooth_reg               <= '0;
            velo_reg                 <= '0;
            stable_reg               <= '0;
            timer_reg                <= '0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (cfg_valid)
                cfg_reg[cfg_index] <= cfg_data;
            // Update hold tracking
            if (state_reg == S_HOLD && hmode_reg)
            begin
                if (jump > 33'(cfg_reg[REG_SW_THR]))
                begin
                    if (tsum[31:0] < 32'(cfg_reg[REG_HOLD_TIME]) && !tsum[32])
                        timer_reg <= tsum[31:0];
                    else
                    begin
                        stable_reg <= d_reg;
                        timer_reg  <= '0;
                    end
                end
                else
                begin
                    stable_reg <= d_reg;
                    timer_reg  <= '0;
                end
            end
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            // Commit the result
            if (state_reg == S_FIN && (!out_valid_reg || m_tready))
            begin
                smooth_reg    <= sat32(res_reg);
                velo_reg      <= sat32(nv_reg);
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (s_tvalid)
                begin
                    d_reg       <= dclamp[31:0];
                    dt_reg      <= s_tdata[47:32];
                    hmode_reg   <= s_tuser;
                    holding_reg <= 1'b0;
                end
            S_HOLD:
                if (hmode_reg && jump > 33'(cfg_reg[REG_SW_THR]) && !tsum[32] &&
                    tsum[31:0] < 32'(cfg_reg[REG_HOLD_TIME]))
                begin
                    d_reg       <= stable_reg;
                    holding_reg <= 1'b1;
                end
            S_DZ:
            begin
                if (dmag <= 33'(cfg_reg[REG_DEADZONE]))
                    d_reg <= smooth_reg;
                om_reg <= {speed[29:0], 1'b0};
            end
            S_MWAIT:
                if (mul_done)
                begin
                    case (op_reg)
                        OP_X:    x_reg    <= mul_result;
                        OP_X2:   x2_reg   <= mul_result;
                        OP_X3:   x3_reg   <= mul_result;
                        OP_P2:   p2_reg   <= mul_result;
                        OP_P3:   p3_reg   <= mul_result;
                        OP_M:    t1_reg   <= satw(64'(velo_reg) + mul_result);
                        OP_TEMP: temp_reg <= satw(mul_result);
                        OP_Q:    av_reg   <= satw(64'(velo_reg) - mul_result);
                        OP_NV:   nv_reg   <= satw(mul_result);
                        OP_R:    res_reg  <= satw(64'(d_reg) + mul_result);
                        OP_STEP: step_reg <= mul_result;
                        default: step_reg <= mul_result;
                    endcase
                end
            S_DWAIT:
                if (div_done)
                    ex_reg <= div_quot;
            S_SNAP:
            begin
                res_reg <= snap_res;
                if ((change < 0) == (res_reg > 64'(d_reg)))
                    nv_reg <= '0;
            end
            S_SLEW:
                if (cfg_reg[REG_MAX_RATE] != '0)
                begin
                    if (res_reg < lo_b)
                        res_reg <= lo_b;
                    else if (res_reg > hi_b)
                        res_reg <= hi_b;
                end
            S_FIN:
                if (!out_valid_reg || m_tready)
                begin
                    out_data_reg <= sat32(res_reg);
                    out_hold_reg <= holding_reg;
                end
            default:
                dt_reg <= dt_reg;
        endcase
    end

endmodule

FILE: tb/tb_focus_distance_smoother.sv
// Testbench for focus_distance_smoother: streams frame ticks through the block,
// predicts every smoothed distance with a bit-exact model and checks the results.
// Depends on fds_pkg and the focus_distance_smoother RTL.
module tb_focus_distance_smoother;
    import fds_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MUL   = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam longint WIDE_MAX  = 64'sd140737488355327;
    localparam int     SETTLE_CYC = 200;

    // Bit-exact prediction of the smoothed focus distance
    class focus_scoreboard;
        longint cfg_reg [NUM_CFG];
        longint prev_out;
        longint velocity;
        longint stable_dist;
        longint unsigned hold_acc;
        logic [32:0] pending_q [$];
        int errors;

        function new();
            cfg_reg[REG_MIN_DIST]  = 0;
            cfg_reg[REG_MAX_DIST]  = 64'h7FFF_FFFF;
            cfg_reg[REG_SW_THR]    = 0;
            cfg_reg[REG_HOLD_TIME] = 0;
            cfg_reg[REG_DEADZONE]  = 0;
            cfg_reg[REG_SPD_CLOSE] = 65536;
            cfg_reg[REG_SPD_FAR]   = 65536;
            cfg_reg[REG_MAX_RATE]  = 0;
            prev_out = 0;
            velocity = 0;
            stable_dist = 0;
            hold_acc = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
            cfg_reg[idx] = longint'(val);
        endfunction

        static function longint wide_sat(longint v);
            if (v > WIDE_MAX) return WIDE_MAX;
            if (v < -WIDE_MAX) return -WIDE_MAX;
            return v;
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Exact product shifted right, truncated toward zero, saturated
        static function longint mul_shift(longint a, longint b, int sh);
            bit neg;
            bit [63:0] ua, ub, r;
            bit [127:0] p, ps;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? -a : a;
            ub = (b < 0) ? -b : b;
            p = {64'b0, ua} * {64'b0, ub};
            ps = p >> sh;
            if (p[127:64] >= (64'd1 << (sh - 2)))
                r = SAT_MUL;
            else
                r = ps[63:0];
            if (r > SAT_MUL)
                r = SAT_MUL;
            return neg ? -longint'(r) : longint'(r);
        endfunction

        // Advance the model by one accepted tick and queue its result
        function void note_tick(logic [31:0] meas, logic [15:0] dt_raw, logic hold_en);
            longint d, dt, lo, hi, t, jump, delta, speed, om, x, x2, x3, den;
            longint change, t1, temp, nv, res, stp;
            longint unsigned ex;
            bit held;
            d = longint'($signed(meas));
            dt = longint'(dt_raw);
            lo = cfg_reg[REG_MIN_DIST];
            hi = cfg_reg[REG_MAX_DIST];
            held = 0;
            if (lo > hi)
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
            if (d < lo) d = lo;
            if (d > hi) d = hi;
            // Hold hysteresis against the last stable distance
            if (hold_en)
            begin
                jump = d - stable_dist;
                if (jump < 0) jump = -jump;
                if (jump > cfg_reg[REG_SW_THR])
                begin
                    hold_acc += longint'(dt);
                    if (hold_acc > 64'hFFFF_FFFF) hold_acc = 64'hFFFF_FFFF;
                    if (hold_acc < cfg_reg[REG_HOLD_TIME])
                    begin
                        d = stable_dist;
                        held = 1;
                    end
                    else
                    begin
                        stable_dist = d;
                        hold_acc = 0;
                    end
                end
                else
                begin
                    stable_dist = d;
                    hold_acc = 0;
                end
            end
            delta = d - prev_out;
            if (((delta < 0) ? -delta : delta) <= cfg_reg[REG_DEADZONE])
                d = prev_out;
            speed = (delta < 0) ? cfg_reg[REG_SPD_CLOSE] : cfg_reg[REG_SPD_FAR];
            if (speed < 65536) speed = 65536;
            if (speed > 655360000) speed = 655360000;
            om = 2 * speed;
            // Rational exponential approximation
            x = mul_shift(om, dt, 16);
            x2 = mul_shift(x, x, 16);
            x3 = mul_shift(x2, x, 16);
            den = 65536 + x + mul_shift(x2, 31457, 16) + mul_shift(x3, 15401, 16);
            ex = (64'd1 << 48) / longint'(den);
            // Spring update
            change = prev_out - d;
            t1 = wide_sat(velocity + mul_shift(om, change, 16));
            temp = wide_sat(mul_shift(t1, dt, 16));
            nv = wide_sat(mul_shift(wide_sat(velocity - mul_shift(om, temp, 16)),
                                    longint'(ex), 32));
            res = wide_sat(d + mul_shift(wide_sat(change + temp), longint'(ex), 32));
            // Snap on overshoot
            if (((d - prev_out) > 0) == (res > d))
            begin
                res = d;
                nv = 0;
            end
            // Slew limit against the previous output
            if (cfg_reg[REG_MAX_RATE] > 0)
            begin
                stp = mul_shift(cfg_reg[REG_MAX_RATE], dt, 16);
                if (res < prev_out - stp) res = prev_out - stp;
                if (res > prev_out + stp) res = prev_out + stp;
            end
            prev_out = clip32(res);
            velocity = clip32(nv);
            pending_q.push_back({held, prev_out[31:0]});
        endfunction

        function void check_result(logic [31:0] focus, logic hold_flag);
            logic [32:0] exp_r;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result focus=%h holding=%b", $time, focus,
                         hold_flag);
                errors++;
                return;
            end
            exp_r = pending_q.pop_front();
            if (exp_r[31:0] !== focus)
            begin
                $display("%0t: focus_distance expected %h actual %h", $time, exp_r[31:0],
                         focus);
                errors++;
            end
            if (exp_r[32] !== hold_flag)
            begin
                $display("%0t: holding expected %b actual %b", $time, exp_r[32], hold_flag);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [47:0] s_tdata = '0;
    logic s_tuser = 0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [31:0] m_tdata;
    logic m_tuser;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    focus_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int recv_block_cyc = 0;
    logic [31:0] scene_dist = 0;

    always #4 clk = ~clk;

    focus_distance_smoother dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Receiver: check each result transaction, then decide the next ready
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
        if (recv_block_cyc > 0)
        begin
            recv_block_cyc <= recv_block_cyc - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_tick(logic [31:0] meas, logic [15:0] dt, logic hold_en);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {dt, meas};
        s_tuser <= hold_en;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_tick(meas, dt, hold_en);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off the sender until every result has come back
    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic load_setting(int kind);
        logic [CFG_W-1:0] v [NUM_CFG];
        case (kind)
            0: v = '{0, 31'h7FFF_FFFF, 0, 0, 0, 65536, 65536, 0};
            1: v = '{31'h7FFF_FFFF, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                     31'h7FFF_FFFF, 0, 31'h7FFF_FFFF};
            2: v = '{0, 31'h7FFF_FFFF, 0, 0, 0, 0, 31'h7FFF_FFFF, 0};
            default:
            begin
                v[REG_MIN_DIST]  = 31'($urandom_range(0, 32'h0020_0000));
                v[REG_MAX_DIST]  = 31'($urandom_range(32'h0040_0000, 32'h7FFF_FFFF));
                v[REG_SW_THR]    = 31'($urandom_range(0, 32'h0008_0000));
                v[REG_HOLD_TIME] = 31'($urandom_range(0, 32'h0003_0000));
                v[REG_DEADZONE]  = 31'($urandom_range(0, 32'h0000_4000));
                v[REG_SPD_CLOSE] = 31'($urandom_range(0, 32'h0020_0000));
                v[REG_SPD_FAR]   = 31'($urandom_range(0, 32'h0020_0000));
                v[REG_MAX_RATE]  = ($urandom_range(2) == 0) ? 31'd0 :
                                   31'($urandom_range(1, 32'h0100_0000));
            end
        endcase
        for (int i = 0; i < NUM_CFG; i++)
            write_reg(i[2:0], v[i]);
    endtask

    // Mostly a settled scene with jitter and jumps, some raw noise
    task automatic random_tick(bit hold_bias);
        logic [31:0] meas;
        logic [15:0] dt;
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            scene_dist = $urandom_range(0, 32'h0100_0000);
        if (pick < 80)
            meas = scene_dist + $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
        else
            meas = $urandom();
        dt = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 65535)) :
                                         16'($urandom_range(300, 4000));
        send_tick(meas, dt, hold_bias ? ($urandom_range(9) != 0) : 1'($urandom_range(1)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: field extremes at reset settings
        send_tick(32'h7FFF_FFFF, 16'd1, 1'b0);
        send_tick(32'h8000_0000, 16'hFFFF, 1'b0);
        send_tick(32'h0000_0000, 16'd1, 1'b1);
        send_tick(32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        send_tick(32'h0010_0000, 16'd1092, 1'b0);
        send_tick(32'h0010_0000, 16'd1092, 1'b0);
        drain();
        // Directed: hold hysteresis, reversed limits, slew
        write_reg(REG_SW_THR, 31'h0001_0000);
        write_reg(REG_HOLD_TIME, 31'h0001_8000);
        send_tick(32'h0005_0000, 16'd1092, 1'b1);
        send_tick(32'h0050_0000, 16'h8000, 1'b1);
        send_tick(32'h0050_0000, 16'h8000, 1'b1);
        send_tick(32'h0050_0000, 16'h8000, 1'b1);
        send_tick(32'h0005_8000, 16'd1092, 1'b1);
        drain();
        write_reg(REG_HOLD_TIME, 31'h7FFF_FFFF);
        write_reg(REG_MIN_DIST, 31'h0040_0000);
        write_reg(REG_MAX_DIST, 31'h0002_0000);
        write_reg(REG_MAX_RATE, 31'h0001_0000);
        write_reg(REG_DEADZONE, 31'h0000_1000);
        repeat (4) send_tick($urandom(), 16'hFFFF, 1'b1);
        send_tick(32'h7FFF_0000, 16'd1, 1'b0);
        drain();
        // Random phases across settings and idle patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph / 4)
                0: begin send_idle_pct = 30; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 30; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_setting(ph % 4 == 3 ? 3 + ph : ph % 4);
            if (ph % 4 == 2)
                recv_block_cyc = 2000;
            for (int n = 0; n < 130; n++)
                random_tick(ph % 2);
            drain();
        end
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
